>>> rtl/ts2c_pkg.sv
// ============================================================================
// ts2c_pkg: shared types and constants for the timestamp to calendar block
// Field widths, divisor constants, the month start table and the stage
// payload structs that pass between the pipeline sections.
// ============================================================================
package ts2c_pkg;

   // Request and response field widths
   localparam int TIME_W  = 49;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DOM_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int MILLI_W = 16;

   // Bus widths, padded to whole bytes
   localparam int REQ_W = 56;
   localparam int RSP_W = 56;

   // Day split: ms-per-day is 2^10 * 84375, so the low 10 bits bypass the divider
   localparam int DAY_LOW_W = 10;
   localparam int DAY_REM_W = 17;
   localparam int DAY_Q_W   = 23;
   localparam logic [DAY_REM_W-1:0] DAY_DIV = 17'd84375;
   localparam int TOD_W     = 27;

   // Calendar period lengths in days
   localparam int DAYS_1Y   = 365;
   localparam int DAYS_4Y   = DAYS_1Y * 4 + 1;
   localparam int DAYS_100Y = DAYS_4Y * 25 - 1;
   localparam int DAYS_400Y = DAYS_100Y * 4 + 1;

   // Time-of-day divisors
   localparam int MS_PER_HOUR   = 3600 * 1000;
   localparam int MS_PER_MINUTE = 60 * 1000;

   localparam int DOY_W = 9;

   // First day of each month within a common year, from the month lengths
   // 31 28 31 30 31 30 31 31 30 31 30 31
   localparam logic [DOY_W-1:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

   // Month start with the leap day folded in after February
   function automatic logic [DOY_W-1:0] month_start(input logic [3:0] m, input logic leap);
      logic [DOY_W-1:0] base;
      base = MONTH_START[m];
      if (leap && (m >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

   // Day number and time of day after the first divider
   typedef struct packed {
      logic               valid;
      logic [DAY_Q_W-1:0] days;
      logic [TOD_W-1:0]   ms;
   } ts2c_day_type;

   // Year, day of year and time fields after the period breakdown
   typedef struct packed {
      logic               valid;
      logic [YEAR_W-1:0]  year;
      logic               leap;
      logic [DOY_W-1:0]   doy;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [MILLI_W-1:0] milli;
   } ts2c_date_type;

   // Finished calendar fields
   typedef struct packed {
      logic               valid;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DOM_W-1:0]   day_of_month;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [MILLI_W-1:0] milli_of_minute;
   } ts2c_cal_type;

endpackage

>>> rtl/ts2c_day_div.sv
// ============================================================================
// ts2c_day_div: millisecond count to day number and time of day
// Four-stage restoring long division of the count by ms-per-day, up to six
// quotient bits per stage, with the low 10 bits carried past the divider.
// ============================================================================
module ts2c_day_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [ts2c_pkg::TIME_W-1:0] in_time,
   output ts2c_pkg::ts2c_day_type      day_out
);
   import ts2c_pkg::*;

   localparam int NSTG  = 4;
   localparam int STEPS = 6;

   logic [NSTG-1:0]      vld_ff;
   logic [DAY_REM_W-1:0] rem_ff [NSTG];
   logic [DAY_Q_W-1:0]   quo_ff [NSTG];
   logic [DAY_Q_W-1:0]   dvd_ff [NSTG];
   logic [DAY_LOW_W-1:0] low_ff [NSTG];

   logic [DAY_REM_W-1:0] src_rem [NSTG];
   logic [DAY_Q_W-1:0]   src_quo [NSTG];
   logic [DAY_Q_W-1:0]   src_dvd [NSTG];
   logic [DAY_LOW_W-1:0] src_low [NSTG];
   logic [DAY_REM_W-1:0] rem_in  [NSTG];
   logic [DAY_Q_W-1:0]   quo_in  [NSTG];

   // Stage sources: the first stage starts with the top 16 bits as remainder
   for (genvar s = 0; s < NSTG; s++) begin : g_src
      if (s == 0) begin : g_first
         assign src_rem[s] = {1'b0, in_time[TIME_W-1:DAY_Q_W+DAY_LOW_W]};
         assign src_quo[s] = '0;
         assign src_dvd[s] = in_time[DAY_Q_W+DAY_LOW_W-1:DAY_LOW_W];
         assign src_low[s] = in_time[DAY_LOW_W-1:0];
      end else begin : g_next
         assign src_rem[s] = rem_ff[s-1];
         assign src_quo[s] = quo_ff[s-1];
         assign src_dvd[s] = dvd_ff[s-1];
         assign src_low[s] = low_ff[s-1];
      end
   end

   // Compare-subtract steps, one quotient bit each
   always_comb begin
      logic [DAY_REM_W:0]   trial;
      logic [DAY_REM_W-1:0] r;
      logic [DAY_Q_W-1:0]   q;
      int                   j;
      for (int s = 0; s < NSTG; s++) begin
         r = src_rem[s];
         q = src_quo[s];
         for (int i = 0; i < STEPS; i++) begin
            j = DAY_Q_W - 1 - s * STEPS - i;
            if (j >= 0) begin
               trial = {r, src_dvd[s][j]};
               if (trial >= {1'b0, DAY_DIV}) begin
                  trial = trial - {1'b0, DAY_DIV};
                  q[j]  = 1'b1;
               end
               r = trial[DAY_REM_W-1:0];
            end
         end
         rem_in[s] = r;
         quo_in[s] = q;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NSTG; s++) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            dvd_ff[s] <= src_dvd[s];
            low_ff[s] <= src_low[s];
         end
      end
   end

   assign day_out.valid = vld_ff[NSTG-1];
   assign day_out.days  = quo_ff[NSTG-1];
   assign day_out.ms    = {rem_ff[NSTG-1], low_ff[NSTG-1]};

   // The final remainder must be a proper remainder
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTG-1] |-> (rem_ff[NSTG-1] < DAY_DIV))
      else $error("day divider remainder out of range");

endmodule

>>> rtl/ts2c_date_split.sv
// ============================================================================
// ts2c_date_split: day number to year and day of year, time of day to fields
// Four stages: 400-year, 100-year, 4-year and 1-year periods, with hour and
// minute split beside the first two of them.
// ============================================================================
module ts2c_date_split (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  ts2c_pkg::ts2c_day_type  day_in,
   output ts2c_pkg::ts2c_date_type date_out
);
   import ts2c_pkg::*;

   localparam logic [DAY_Q_W-1:0] D400 = DAY_Q_W'(DAYS_400Y);
   localparam logic [17:0]        D100 = 18'(DAYS_100Y);
   localparam logic [15:0]        D4   = 16'(DAYS_4Y);
   localparam logic [10:0]        D1   = 11'(DAYS_1Y);
   localparam logic [TOD_W-1:0]   DHR  = TOD_W'(MS_PER_HOUR);
   localparam logic [21:0]        DMIN = 22'(MS_PER_MINUTE);

   // Stage A registers
   logic              sa_vld_ff;
   logic [5:0]        sa_q400_ff, sa_q400_in;
   logic [17:0]       sa_rest_ff, sa_rest_in;
   logic [HOUR_W-1:0] sa_hour_ff, sa_hour_in;
   logic [21:0]       sa_msr_ff, sa_msr_in;

   // Stage B registers
   logic               sb_vld_ff;
   logic [5:0]         sb_q400_ff;
   logic [1:0]         sb_q100_ff, sb_q100_in;
   logic [15:0]        sb_rest_ff, sb_rest_in;
   logic [HOUR_W-1:0]  sb_hour_ff;
   logic [MIN_W-1:0]   sb_min_ff, sb_min_in;
   logic [MILLI_W-1:0] sb_milli_ff, sb_milli_in;

   // Stage C registers
   logic               sc_vld_ff;
   logic [5:0]         sc_q400_ff;
   logic [1:0]         sc_q100_ff;
   logic [4:0]         sc_q4_ff, sc_q4_in;
   logic [10:0]        sc_rest_ff, sc_rest_in;
   logic [HOUR_W-1:0]  sc_hour_ff;
   logic [MIN_W-1:0]   sc_min_ff;
   logic [MILLI_W-1:0] sc_milli_ff;

   // Stage D output register
   ts2c_date_type date_ff, date_in;

   // Stage A: clamp day zero, 400-year periods, hours
   always_comb begin
      logic [DAY_Q_W-1:0] r;
      logic [TOD_W-1:0]   t;
      r = (day_in.days == '0) ? '0 : day_in.days - 1'b1;
      sa_q400_in = '0;
      for (int i = 5; i >= 0; i--) begin
         if (r >= (D400 << i)) begin
            r = r - (D400 << i);
            sa_q400_in[i] = 1'b1;
         end
      end
      sa_rest_in = r[17:0];
      t = day_in.ms;
      sa_hour_in = '0;
      for (int i = HOUR_W - 1; i >= 0; i--) begin
         if (t >= (DHR << i)) begin
            t = t - (DHR << i);
            sa_hour_in[i] = 1'b1;
         end
      end
      sa_msr_in = t[21:0];
   end

   // Stage B: 100-year periods with the last-day fold, minutes
   always_comb begin
      logic [17:0] r;
      logic [2:0]  q;
      logic [21:0] t;
      r = sa_rest_ff;
      q = '0;
      for (int i = 2; i >= 0; i--) begin
         if (r >= (D100 << i)) begin
            r = r - (D100 << i);
            q[i] = 1'b1;
         end
      end
      if (q == 3'd4) begin
         q = 3'd3;
         r = r + D100;
      end
      sb_q100_in = q[1:0];
      sb_rest_in = r[15:0];
      t = sa_msr_ff;
      sb_min_in = '0;
      for (int i = MIN_W - 1; i >= 0; i--) begin
         if (t >= (DMIN << i)) begin
            t = t - (DMIN << i);
            sb_min_in[i] = 1'b1;
         end
      end
      sb_milli_in = t[MILLI_W-1:0];
   end

   // Stage C: 4-year periods
   always_comb begin
      logic [15:0] r;
      r = sb_rest_ff;
      sc_q4_in = '0;
      for (int i = 4; i >= 0; i--) begin
         if (r >= (D4 << i)) begin
            r = r - (D4 << i);
            sc_q4_in[i] = 1'b1;
         end
      end
      sc_rest_in = r[10:0];
   end

   // Stage D: single years with the last-day fold, leap flag, year sum
   always_comb begin
      logic [10:0] r;
      logic [2:0]  q;
      logic [14:0] yr;
      r = sc_rest_ff;
      q = '0;
      for (int i = 2; i >= 0; i--) begin
         if (r >= (D1 << i)) begin
            r = r - (D1 << i);
            q[i] = 1'b1;
         end
      end
      if (q == 3'd4) begin
         q = 3'd3;
         r = r + D1;
      end
      yr = 15'd1 + 15'(sc_q400_ff) * 15'd400 + 15'(sc_q100_ff) * 15'd100
         + 15'(sc_q4_ff) * 15'd4 + 15'(q);
      date_in.valid  = sc_vld_ff;
      date_in.year   = yr[YEAR_W-1:0];
      // Fourth year of a 4-year period, except a century year not divisible by 400
      date_in.leap   = (q == 3'd3) && ((sc_q4_ff != 5'd24) || (sc_q100_ff == 2'd3));
      date_in.doy    = r[DOY_W-1:0];
      date_in.hour   = sc_hour_ff;
      date_in.minute = sc_min_ff;
      date_in.milli  = sc_milli_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff     <= 1'b0;
         sb_vld_ff     <= 1'b0;
         sc_vld_ff     <= 1'b0;
         date_ff.valid <= 1'b0;
      end else if (en) begin
         sa_vld_ff     <= day_in.valid;
         sb_vld_ff     <= sa_vld_ff;
         sc_vld_ff     <= sb_vld_ff;
         date_ff.valid <= date_in.valid;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         sa_q400_ff     <= sa_q400_in;
         sa_rest_ff     <= sa_rest_in;
         sa_hour_ff     <= sa_hour_in;
         sa_msr_ff      <= sa_msr_in;
         sb_q400_ff     <= sa_q400_ff;
         sb_q100_ff     <= sb_q100_in;
         sb_rest_ff     <= sb_rest_in;
         sb_hour_ff     <= sa_hour_ff;
         sb_min_ff      <= sb_min_in;
         sb_milli_ff    <= sb_milli_in;
         sc_q400_ff     <= sb_q400_ff;
         sc_q100_ff     <= sb_q100_ff;
         sc_q4_ff       <= sc_q4_in;
         sc_rest_ff     <= sc_rest_in;
         sc_hour_ff     <= sb_hour_ff;
         sc_min_ff      <= sb_min_ff;
         sc_milli_ff    <= sb_milli_ff;
         date_ff.year   <= date_in.year;
         date_ff.leap   <= date_in.leap;
         date_ff.doy    <= date_in.doy;
         date_ff.hour   <= date_in.hour;
         date_ff.minute <= date_in.minute;
         date_ff.milli  <= date_in.milli;
      end
   end

   assign date_out = date_ff;

   // Time fields stay within a day
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      date_ff.valid |-> (date_ff.hour < 5'd24) && (date_ff.minute < 6'd60)
                     && (date_ff.milli < 16'd60000))
      else $error("time of day fields out of range");

   // Only a leap year reaches day of year 365
   a_doy_range: assert property (@(posedge clock) disable iff (reset)
      date_ff.valid && !date_ff.leap |-> (date_ff.doy < 9'd365))
      else $error("day of year past end of common year");

endmodule

>>> rtl/ts2c_month_walk.sv
// ============================================================================
// ts2c_month_walk: day of year to month and day of month
// One stage of parallel compares against the month start table, feeding
// the response register.
// ============================================================================
module ts2c_month_walk (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  ts2c_pkg::ts2c_date_type date_in,
   output ts2c_pkg::ts2c_cal_type  cal_out
);
   import ts2c_pkg::*;

   ts2c_cal_type cal_ff, cal_in;

   // Last month whose start is not past the day of year
   always_comb begin
      logic [3:0]       m;
      logic [DOY_W-1:0] st;
      logic [DOY_W-1:0] dom;
      m  = '0;
      st = '0;
      for (int k = 1; k < 12; k++) begin
         if (date_in.doy >= month_start(4'(k), date_in.leap)) begin
            m  = 4'(k);
            st = month_start(4'(k), date_in.leap);
         end
      end
      dom = date_in.doy - st + 9'd1;
      cal_in.valid           = date_in.valid;
      cal_in.year            = date_in.year;
      cal_in.month           = m + 4'd1;
      cal_in.day_of_month    = dom[DOM_W-1:0];
      cal_in.hour            = date_in.hour;
      cal_in.minute          = date_in.minute;
      cal_in.milli_of_minute = date_in.milli;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.valid <= 1'b0;
      end else if (en) begin
         cal_ff.valid <= cal_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cal_ff.year            <= cal_in.year;
         cal_ff.month           <= cal_in.month;
         cal_ff.day_of_month    <= cal_in.day_of_month;
         cal_ff.hour            <= cal_in.hour;
         cal_ff.minute          <= cal_in.minute;
         cal_ff.milli_of_minute <= cal_in.milli_of_minute;
      end
   end

   assign cal_out = cal_ff;

   // Month and day stay on the calendar
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      cal_ff.valid |-> (cal_ff.month >= 4'd1) && (cal_ff.month <= 4'd12)
                    && (cal_ff.day_of_month >= 5'd1) && (cal_ff.day_of_month <= 5'd31))
      else $error("month or day of month out of range");

endmodule

>>> rtl/timestamp_to_calendar_fields.sv
// ============================================================================
// timestamp_to_calendar_fields: millisecond count to Gregorian date and time
// Top level: request and response streams around a nine-stage pipeline.
// ============================================================================
// Each request carries a millisecond count in which 0001-01-01 starts at
// 86400000; counts below that fall on 0001-01-01. The response gives year,
// month, day of month, hour, minute and milliseconds within the minute, one
// response per request, in order. The pipeline takes one request per clock
// while not stalled, and each request passes through four stages of long
// division by ms-per-day, four stages of calendar period breakdown and one
// month-table stage that is also the response register. When the response
// is held by the consumer the whole pipeline stalls together.
module timestamp_to_calendar_fields (
   input  logic                       clock,
   input  logic                       reset,
   // request: [48:0] time_ms, [55:49] zero
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [ts2c_pkg::REQ_W-1:0] req_tdata,
   // response: [13:0] year, [17:14] month, [22:18] day_of_month,
   // [27:23] hour, [33:28] minute, [49:34] milli_of_minute, [55:50] zero
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [ts2c_pkg::RSP_W-1:0] rsp_tdata
);
   import ts2c_pkg::*;

   logic          en;
   ts2c_day_type  day_w;
   ts2c_date_type date_w;
   ts2c_cal_type  cal_w;

   // Pipeline advances unless a finished response is waiting
   assign en         = rsp_tready || !cal_w.valid;
   assign req_tready = en;

   ts2c_day_div u_day_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_time  (req_tdata[TIME_W-1:0]),
      .day_out  (day_w)
   );

   ts2c_date_split u_date_split (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .day_in   (day_w),
      .date_out (date_w)
   );

   ts2c_month_walk u_month_walk (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .date_in (date_w),
      .cal_out (cal_w)
   );

   // Response packing
   assign rsp_tvalid = cal_w.valid;
   assign rsp_tdata  = {6'd0, cal_w.milli_of_minute, cal_w.minute, cal_w.hour,
                        cal_w.day_of_month, cal_w.month, cal_w.year};

   // Requests are refused only while a response sits unaccepted
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without a held response");

endmodule
